@@ rtl/rpp_pkg.sv @@
// Shared widths, sizes and kind codes for the reader progress percentile unit.
package rpp_pkg;

	localparam int USER_SLOTS = 131072;
	localparam int PAGE_SLOTS = 1024;

	localparam int USER_W  = $clog2(USER_SLOTS);
	localparam int PAGE_W  = 11;
	localparam int HADDR_W = $clog2(PAGE_SLOTS);
	localparam int CNT_W   = USER_W + 1;
	localparam int FRAC_W  = 16;
	localparam int RATIO_W = FRAC_W + 1;
	localparam int DIVD_W  = CNT_W + FRAC_W;
	localparam int DIVS_W  = USER_W;
	localparam int STEP_W  = $clog2(DIVD_W + 1);

	localparam int IN_DATA_W  = ((USER_W + PAGE_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((RATIO_W + 7) / 8) * 8;

	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1 << FRAC_W);

	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic             start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ rtl/rpp_div.sv @@
// Restoring bit-serial divider: one quotient bit per cycle.
module rpp_div (
	input  logic            clk,
	input  logic            arst_n,
	input  rpp_pkg::div_req_t req,
	output rpp_pkg::div_rsp_t rsp
);
	import rpp_pkg::*;

	logic [DIVD_W-1:0] dq_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVS_W:0]   trial;
	logic [DIVS_W:0]   diff;
	logic              fits;

	assign trial = {rem_q, dq_q[DIVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
			dq_q  <= {dq_q[DIVD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

endmodule

@@ rtl/reader_progress_percentile_unit.sv @@
// Top level: user page table, page histogram, sequencer and result register.
//
// Input stream: s_tuser carries kind (0 record a page, 1 query a standing);
// s_tdata carries user_id in bits 16:0 and page in bits 27:17.
// A record moves the user to the given page and updates the histogram; it
// gives no result. A query gives one result on m_tdata bits 16:0: the share
// of the other known users on lower pages, 16 fraction bits, 65536 = one.
// Items are handled one at a time; s_tready is high only while idle.
// A record reads the user table, decrements the histogram at the old page
// (skipped for a user seen for the first time) and increments it at the new
// page; a record with its page out of range is dropped while idle. A query
// sums the histogram entries below the user's page, one entry per cycle
// through the single histogram read port, drains the read, then runs the
// divider (start, 34 bit-serial steps, done). A query of an unknown user
// gives 0, and 65536 when only one user is known. After reset the block clears
// the user page table and the histogram, one entry a cycle, with s_tready low.
// The result sits in an output register; while the receiver stalls, the next
// item is still taken, and a following query waits at its end for the slot.
module reader_progress_percentile_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [rpp_pkg::IN_DATA_W-1:0]    s_tdata,  // user_id, page, zero fill
	input  logic                             s_tuser,  // kind
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [rpp_pkg::OUT_DATA_W-1:0]   m_tdata   // ratio, zero fill
);
	import rpp_pkg::*;

	localparam logic [3:0] ST_CLR    = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_UT     = 4'd2;
	localparam logic [3:0] ST_DEC_RD = 4'd3;
	localparam logic [3:0] ST_DEC_WR = 4'd4;
	localparam logic [3:0] ST_INC_RD = 4'd5;
	localparam logic [3:0] ST_INC_WR = 4'd6;
	localparam logic [3:0] ST_SUM    = 4'd7;
	localparam logic [3:0] ST_DIV    = 4'd8;
	localparam logic [3:0] ST_WAIT   = 4'd9;
	localparam logic [3:0] ST_OUT    = 4'd10;

	logic [PAGE_W-1:0] ut_mem [USER_SLOTS];
	cnt_t              hist_mem [PAGE_SLOTS];

	logic [3:0]         state_q;
	logic [USER_W-1:0]  clr_q;
	logic               kind_q;
	logic [USER_W-1:0]  user_q;
	logic [PAGE_W-1:0]  page_q;
	logic [PAGE_W-1:0]  pg_q;
	logic [PAGE_W-1:0]  ut_rd_q;
	cnt_t               hist_rd_q;
	cnt_t               known_q;
	cnt_t               acc_q;
	logic [PAGE_W-1:0]  idx_q;
	logic               issue_q;
	logic [RATIO_W-1:0] res_q;
	logic [RATIO_W-1:0] out_q;
	logic               out_valid_q;

	logic [USER_W-1:0]  in_user;
	logic [PAGE_W-1:0]  in_page;
	logic               in_page_ok;
	logic               accept;
	logic               ut_we;
	logic [USER_W-1:0]  ut_waddr;
	logic [PAGE_W-1:0]  ut_wdata;
	logic               h_we;
	logic [HADDR_W-1:0] h_waddr;
	cnt_t               h_wdata;
	logic [HADDR_W-1:0] h_raddr;
	logic [PAGE_W-1:0]  old_m1;
	logic [PAGE_W-1:0]  lim;
	logic               out_free;
	div_req_t           dreq;
	div_rsp_t           drsp;

	assign in_user    = s_tdata[USER_W-1:0];
	assign in_page    = s_tdata[USER_W +: PAGE_W];
	assign in_page_ok = (in_page != '0) && (in_page <= PAGE_W'(PAGE_SLOTS));
	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign old_m1     = pg_q - 1'b1;
	assign lim        = pg_q - 1'b1;
	assign out_free   = !out_valid_q || m_tready;

	rpp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_comb begin
		dreq.start    = (state_q == ST_DIV);
		dreq.dividend = {acc_q, FRAC_W'(0)};
		dreq.divisor  = DIVS_W'(known_q - 1'b1);
	end

	// user page table port control
	always_comb begin
		ut_we    = 1'b0;
		ut_waddr = user_q;
		ut_wdata = page_q;
		if (state_q == ST_CLR) begin
			ut_we    = 1'b1;
			ut_waddr = clr_q;
			ut_wdata = '0;
		end else if (state_q == ST_UT && kind_q == KIND_RECORD) begin
			ut_we = 1'b1;
		end
	end

	// histogram port control
	always_comb begin
		h_we    = 1'b0;
		h_waddr = clr_q[HADDR_W-1:0];
		h_wdata = '0;
		h_raddr = idx_q[HADDR_W-1:0];
		case (state_q)
			ST_CLR: begin
				h_we = 1'b1;
			end
			ST_DEC_RD: begin
				h_raddr = old_m1[HADDR_W-1:0];
			end
			ST_DEC_WR: begin
				h_we    = 1'b1;
				h_waddr = old_m1[HADDR_W-1:0];
				h_wdata = hist_rd_q - cnt_t'(hist_rd_q != '0);
			end
			ST_INC_RD: begin
				h_raddr = HADDR_W'(page_q - 1'b1);
			end
			ST_INC_WR: begin
				h_we    = 1'b1;
				h_waddr = HADDR_W'(page_q - 1'b1);
				h_wdata = hist_rd_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ut_we) begin
			ut_mem[ut_waddr] <= ut_wdata;
		end
		ut_rd_q <= ut_mem[in_user];
	end

	always_ff @(posedge clk) begin
		if (h_we) begin
			hist_mem[h_waddr] <= h_wdata;
		end
		hist_rd_q <= hist_mem[h_raddr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser;
			user_q <= in_user;
			page_q <= in_page;
		end
		if (state_q == ST_UT) begin
			pg_q <= ut_rd_q;
		end
		if (state_q == ST_WAIT && drsp.done) begin
			res_q <= (drsp.quotient > DIVD_W'(RATIO_ONE)) ? RATIO_ONE
			                                              : drsp.quotient[RATIO_W-1:0];
		end else if (state_q == ST_UT) begin
			res_q <= (ut_rd_q == '0) ? '0 : RATIO_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			known_q     <= '0;
			acc_q       <= '0;
			idx_q       <= '0;
			issue_q     <= 1'b0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			// pipelined prefix sum: data arrives in the cycle after its read
			if (issue_q) begin
				acc_q <= acc_q + hist_rd_q;
			end
			issue_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == KIND_RECORD && !in_page_ok) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_UT;
						end
					end
				end
				ST_UT: begin
					if (kind_q == KIND_RECORD) begin
						if (ut_rd_q == '0) begin
							known_q <= known_q + 1'b1;
							state_q <= ST_INC_RD;
						end else begin
							state_q <= ST_DEC_RD;
						end
					end else if (ut_rd_q == '0 || known_q <= cnt_t'(1)) begin
						state_q <= ST_OUT;
					end else begin
						acc_q   <= '0;
						idx_q   <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_DEC_RD: state_q <= ST_DEC_WR;
				ST_DEC_WR: state_q <= ST_INC_RD;
				ST_INC_RD: state_q <= ST_INC_WR;
				ST_INC_WR: state_q <= ST_IDLE;
				ST_SUM: begin
					if (idx_q < lim) begin
						idx_q   <= idx_q + 1'b1;
						issue_q <= 1'b1;
					end else if (!issue_q) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (drsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W - RATIO_W)'(0), out_q};

endmodule

@@ bench/reader_progress_percentile_unit_test.sv @@
// Self-checking bench for the reader progress percentile unit: page records and standing queries.
module reader_progress_percentile_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rpp_pkg::*;

	localparam int LIMIT = 5_000_000;
	localparam int DRAIN = 1200;
	localparam int POOL  = 48;

	// Tracks pages per user and users per page; queues the ratio each query should return.
	class standing_board;
		int unsigned page_of_user [int unsigned];
		int unsigned users_on_page [PAGE_SLOTS];
		int unsigned known;
		logic [RATIO_W-1:0] ratios_due [$];
		int unsigned failures;

		function new();
			known = 0;
			failures = 0;
			foreach (users_on_page[i]) users_on_page[i] = 0;
		endfunction

		function int unsigned pending();
			return ratios_due.size();
		endfunction

		function logic [RATIO_W-1:0] standing_of(logic [USER_W-1:0] user);
			longint unsigned below;
			longint unsigned quot;
			int unsigned pg;
			if (!page_of_user.exists(user)) return '0;
			if (known <= 1) return RATIO_ONE;
			pg = page_of_user[user];
			below = 0;
			for (int i = 0; i < pg - 1; i++) below += users_on_page[i];
			quot = (below << FRAC_W) / (known - 1);
			if (quot > RATIO_ONE) quot = RATIO_ONE;
			return RATIO_W'(quot);
		endfunction

		function void take_item(logic kind, logic [USER_W-1:0] user, logic [PAGE_W-1:0] page);
			int unsigned prior;
			if (kind == KIND_QUERY) begin
				ratios_due.push_back(standing_of(user));
				return;
			end
			// out-of-range page: dropped without touching state
			if (page == 0 || page > PAGE_SLOTS) return;
			if (!page_of_user.exists(user)) begin
				known++;
			end else begin
				prior = page_of_user[user];
				if (users_on_page[prior-1] > 0) users_on_page[prior-1]--;
			end
			users_on_page[page-1]++;
			page_of_user[user] = page;
		endfunction

		function void check_ratio(logic [OUT_DATA_W-1:0] data);
			logic [RATIO_W-1:0] want;
			if (ratios_due.size() == 0) begin
				if (failures < 10) $display("unexpected result transaction: ratio %0d",
					data[RATIO_W-1:0]);
				failures++;
				return;
			end
			want = ratios_due.pop_front();
			if (data[RATIO_W-1:0] !== want) begin
				if (failures < 10) $display("ratio mismatch: expected %0d, got %0d",
					want, data[RATIO_W-1:0]);
				failures++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;  // user_id, page, zero fill
	logic                  s_tuser = 1'b0; // kind
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // ratio, zero fill

	bit          calm = 1'b0;
	int unsigned cycles = 0;
	standing_board board = new();

	reader_progress_percentile_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	// Result side: signals read here are the values sampled at this edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready) board.check_ratio(m_tdata);
		m_tready <= calm || ($urandom_range(99) >= 36);
	end

	initial begin
		wait (cycles >= LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	task automatic offer_item(logic kind, logic [USER_W-1:0] user, logic [PAGE_W-1:0] page);
		while (!calm && $urandom_range(99) < 36) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= IN_DATA_W'({page, user});
		do @(posedge clk); while (!s_tready);
		board.take_item(kind, user, page);
	endtask

	initial begin
		logic [USER_W-1:0] pool [POOL];
		logic [USER_W-1:0] user;
		logic [PAGE_W-1:0] page;
		int roll;

		pool[0] = '0;
		pool[1] = '1;
		for (int i = 2; i < POOL; i++) pool[i] = USER_W'($urandom);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, single user, extremes, dropped pages, moves
		offer_item(KIND_QUERY,  '0, PAGE_W'($urandom));
		offer_item(KIND_RECORD, '0, PAGE_W'(PAGE_SLOTS));
		offer_item(KIND_QUERY,  '0, '1);
		offer_item(KIND_RECORD, '1, 1);
		offer_item(KIND_QUERY,  '1, '0);
		offer_item(KIND_QUERY,  '0, PAGE_W'($urandom));
		offer_item(KIND_RECORD, '1, 0);
		offer_item(KIND_RECORD, '1, '1);
		offer_item(KIND_RECORD, '1, PAGE_W'(PAGE_SLOTS + 1));
		offer_item(KIND_QUERY,  '1, PAGE_W'($urandom));
		offer_item(KIND_RECORD, '1, 1);  // same page again
		offer_item(KIND_RECORD, 5, 512);
		offer_item(KIND_QUERY,  '0, PAGE_W'($urandom));
		offer_item(KIND_QUERY,  5, PAGE_W'($urandom));
		offer_item(KIND_RECORD, '0, 1);  // move down
		offer_item(KIND_QUERY,  5, PAGE_W'($urandom));
		offer_item(KIND_QUERY,  '0, PAGE_W'($urandom));
		offer_item(KIND_QUERY,  77, PAGE_W'($urandom));
		offer_item(KIND_RECORD, 3, 3);
		offer_item(KIND_QUERY,  3, PAGE_W'($urandom));  // truncated two thirds
		offer_item(KIND_RECORD, 3, 2);
		offer_item(KIND_QUERY,  3, PAGE_W'($urandom));

		// hold off until the pipe is drained
		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);

		for (int n = 0; n < 500; n++) begin
			calm <= (n >= 200 && n < 280);
			roll = $urandom_range(99);
			if (roll < 45) begin
				user = ($urandom_range(99) < 85) ? pool[$urandom_range(POOL-1)]
					: USER_W'($urandom);
				roll = $urandom_range(99);
				if (roll < 80)      page = PAGE_W'($urandom_range(64, 1));
				else if (roll < 92) page = PAGE_W'($urandom_range(PAGE_SLOTS, 1));
				else if (roll < 96) page = PAGE_W'($urandom_range(2047, PAGE_SLOTS + 1));
				else                page = '0;
				offer_item(KIND_RECORD, user, page);
			end else begin
				user = ($urandom_range(99) < 90) ? pool[$urandom_range(POOL-1)]
					: USER_W'($urandom);
				offer_item(KIND_QUERY, user, PAGE_W'($urandom));
			end
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
		repeat (DRAIN) @(posedge clk);
		if (board.failures == 0 && board.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
